/* hw/rtl/fkrs_pkg.sv */
// shared types, constants and key mapping functions of the float key sorter
`timescale 1ns / 1ps

package fkrs_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int KEY_W         = 32;
    localparam logic [KEY_W-1:0] SIGN_MASK = 32'h8000_0000;

    // one input beat
    typedef struct packed {
        logic [KEY_W-1:0] key_bits;
        logic             is_last;
    } key_beat_t;

    // one result beat
    typedef struct packed {
        logic [KEY_W-1:0] sorted_bits;
        logic             last_out;
    } result_beat_t;

    // one slot of the sorting chain: occupied flag and ordered code
    typedef struct packed {
        logic             occ;
        logic [KEY_W-1:0] code;
    } slot_t;

    // float bit pattern to order-preserving unsigned code
    function automatic logic [KEY_W-1:0] to_code(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] c;
        if ((k & SIGN_MASK) != '0)
            c = ~k;
        else
            c = k ^ SIGN_MASK;
        return c;
    endfunction

    // unsigned code back to float bit pattern
    function automatic logic [KEY_W-1:0] from_code(input logic [KEY_W-1:0] c);
        logic [KEY_W-1:0] k;
        if ((c & SIGN_MASK) != '0)
            k = c ^ SIGN_MASK;
        else
            k = ~c;
        return k;
    endfunction

endpackage

/* hw/rtl/fkrs_cell.sv */
// one cell of the sorting chain: keeps the smaller code, passes the larger one on
`timescale 1ns / 1ps

module fkrs_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  fkrs_pkg::slot_t from_left,
    input  fkrs_pkg::slot_t right_held,
    output fkrs_pkg::slot_t held,
    output fkrs_pkg::slot_t to_right
);

    fkrs_pkg::slot_t held_reg;
    fkrs_pkg::slot_t held_next;
    fkrs_pkg::slot_t pass_reg;
    fkrs_pkg::slot_t pass_next;

    // insert or shift towards the head
    always_comb
    begin
        held_next = held_reg;
        pass_next = '0;
        if (shift)
        begin
            held_next = right_held;
        end
        else if (from_left.occ)
        begin
            if (!held_reg.occ)
            begin
                held_next = from_left;
            end
            else if (from_left.code < held_reg.code)
            begin
                held_next = from_left;
                pass_next = held_reg;
            end
            else
            begin
                pass_next = from_left;
            end
        end
    end

    // slot and outgoing link registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            pass_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
            pass_reg <= pass_next;
        end
    end

    assign held     = held_reg;
    assign to_right = pass_reg;

endmodule

/* hw/rtl/float_key_radix_sorter_unit.sv */
// Float key sorter: keys of a set are taken one per cycle while the block is collecting; each
// key is turned into an order-preserving code and enters a chain of DEPTH compare cells, moving
// one cell per cycle. The beat marked is_last closes the set; once the chain has settled, the set
// is emitted in ascending order, one result per cycle while the receiver does not stall (last one
// marked), by shifting the chain towards its head. Keys beyond DEPTH in one set are dropped, but
// their is_last mark still closes the set. No keys are taken while settling or emitting.
`timescale 1ns / 1ps

module float_key_radix_sorter_unit
#(
    parameter int DEPTH = fkrs_pkg::DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   key_valid,
    output logic                   key_stall,
    input  fkrs_pkg::key_beat_t    key_beat,
    output logic                   result_valid,
    input  logic                   result_stall,
    output fkrs_pkg::result_beat_t result_beat
);

    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SETTLE_W = $clog2(DEPTH + 2);

    typedef enum logic [1:0] {
        COLLECT,
        SETTLE,
        EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       remain_reg, remain_next;
    logic [SETTLE_W-1:0]    settle_reg, settle_next;
    fkrs_pkg::slot_t        inject_reg, inject_next;
    logic                   out_valid_reg, out_valid_next;
    fkrs_pkg::result_beat_t out_beat_reg, out_beat_next;

    fkrs_pkg::slot_t link [DEPTH+1];
    fkrs_pkg::slot_t held [DEPTH+1];

    logic key_take;
    logic res_take;
    logic load;
    logic room;

    assign key_stall = (state_reg != COLLECT);
    assign key_take  = key_valid && !key_stall;
    assign res_take  = out_valid_reg && !result_stall;
    assign load      = (state_reg == EMIT) && (!out_valid_reg || res_take);
    assign room      = (count_reg < CNT_W'(DEPTH));

    // chain of compare cells
    assign link[0]     = inject_reg;
    assign held[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        fkrs_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (load),
            .from_left  (link[i]),
            .right_held (held[i+1]),
            .held       (held[i]),
            .to_right   (link[i+1])
        );
    end

    // sequencing of collect, settle and emit
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        settle_next    = settle_reg;
        inject_next    = '0;
        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;

        if (res_take)
            out_valid_next = 1'b0;

        unique case (state_reg)
            COLLECT:
            begin
                if (key_take)
                begin
                    inject_next.occ  = room;
                    inject_next.code = fkrs_pkg::to_code(key_beat.key_bits);
                    count_next       = count_reg + CNT_W'(room);
                    if (key_beat.is_last)
                    begin
                        remain_next = count_next;
                        count_next  = '0;
                        settle_next = '0;
                        state_next  = SETTLE;
                    end
                end
            end
            SETTLE:
            begin
                settle_next = settle_reg + 1'b1;
                if (settle_reg == SETTLE_W'(DEPTH))
                    state_next = EMIT;
            end
            EMIT:
            begin
                if (load)
                begin
                    out_valid_next            = 1'b1;
                    out_beat_next.sorted_bits = fkrs_pkg::from_code(held[0].code);
                    out_beat_next.last_out    = (remain_reg == CNT_W'(1));
                    remain_next               = remain_reg - 1'b1;
                    if (remain_reg == CNT_W'(1))
                        state_next = COLLECT;
                end
            end
            default:
            begin
                state_next = COLLECT;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= COLLECT;
            count_reg     <= '0;
            remain_reg    <= '0;
            settle_reg    <= '0;
            inject_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_beat_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            settle_reg    <= settle_next;
            inject_reg    <= inject_next;
            out_valid_reg <= out_valid_next;
            out_beat_reg  <= out_beat_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_beat  = out_beat_reg;

endmodule

/* hw/rtl/fkrs_checker.sv */
// port-level checks of the float key sorter and their binding
`timescale 1ns / 1ps

module fkrs_checker
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   key_valid,
    input logic                   key_stall,
    input fkrs_pkg::key_beat_t    key_beat,
    input logic                   result_valid,
    input logic                   result_stall,
    input fkrs_pkg::result_beat_t result_beat
);

    // stalled result beat stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat withdrawn while stalled");

    // stalled result beat keeps its payload
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result_beat))
        else $error("result payload changed while stalled");

    // closing a set starts sorting, no key taken next cycle
    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_stall && key_beat.is_last |=> key_stall)
        else $error("key input open right after the set was closed");

    // no new key while a set is still being emitted
    a_emit_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result_beat.last_out |-> key_stall)
        else $error("key input open in the middle of a sorted set");

endmodule

bind float_key_radix_sorter_unit fkrs_checker u_fkrs_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .key_valid    (key_valid),
    .key_stall    (key_stall),
    .key_beat     (key_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
);

/* tb/sv/fkrs_sort_checker.sv */
// checker for the float key sorter: rebuilds each sorted set and compares the result beats
`timescale 1ns / 1ps

module fkrs_sort_checker
#(
    parameter int DEPTH = fkrs_pkg::DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   key_valid,
    input  logic                   key_stall,
    input  fkrs_pkg::key_beat_t    key_beat,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  fkrs_pkg::result_beat_t result_beat,
    output int                     fail_count,
    output int                     pending
);

    localparam int MAX_REPORTS = 200;

    // order codes of the set being collected
    logic [fkrs_pkg::KEY_W-1:0] set_codes[$];
    // sorted keys still owed by the block, oldest first
    fkrs_pkg::result_beat_t sorted_q[$];
    fkrs_pkg::result_beat_t want;

    // negative keys invert fully, the rest only flip the sign bit
    function automatic logic [fkrs_pkg::KEY_W-1:0] key_to_order(
        input logic [fkrs_pkg::KEY_W-1:0] k);
        return k[fkrs_pkg::KEY_W-1] ? ~k : {1'b1, k[fkrs_pkg::KEY_W-2:0]};
    endfunction

    function automatic logic [fkrs_pkg::KEY_W-1:0] order_to_key(
        input logic [fkrs_pkg::KEY_W-1:0] c);
        return c[fkrs_pkg::KEY_W-1] ? {1'b0, c[fkrs_pkg::KEY_W-2:0]} : ~c;
    endfunction

    // stable split on each code bit, least significant first
    function automatic void order_set();
        logic [fkrs_pkg::KEY_W-1:0] zeros[$];
        logic [fkrs_pkg::KEY_W-1:0] ones[$];
        for (int b = 0; b < fkrs_pkg::KEY_W; b++)
        begin
            zeros.delete();
            ones.delete();
            foreach (set_codes[j])
            begin
                if (set_codes[j][b])
                    ones.push_back(set_codes[j]);
                else
                    zeros.push_back(set_codes[j]);
            end
            set_codes = zeros;
            foreach (ones[j])
                set_codes.push_back(ones[j]);
        end
    endfunction

    // sort the closed set and queue its keys, marking the final one
    function automatic void close_set();
        fkrs_pkg::result_beat_t r;
        order_set();
        foreach (set_codes[j])
        begin
            r.sorted_bits = order_to_key(set_codes[j]);
            r.last_out    = (j == set_codes.size() - 1);
            sorted_q.push_back(r);
        end
        set_codes.delete();
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_REPORTS)
            $display("%0d ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_codes.delete();
            sorted_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // result beat against the oldest owed key
            if (result_valid && !result_stall)
            begin
                if (sorted_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %h last %b",
                        result_beat.sorted_bits, result_beat.last_out));
                end
                else
                begin
                    want = sorted_q.pop_front();
                    if (result_beat.sorted_bits !== want.sorted_bits ||
                        result_beat.last_out !== want.last_out)
                        report_mismatch($sformatf("got %h last %b, want %h last %b",
                            result_beat.sorted_bits, result_beat.last_out,
                            want.sorted_bits, want.last_out));
                end
            end
            // key beat into the open set, dropped once the set is full
            if (key_valid && !key_stall)
            begin
                if (set_codes.size() < DEPTH)
                    set_codes.push_back(key_to_order(key_beat.key_bits));
                if (key_beat.is_last)
                    close_set();
            end
            pending = sorted_q.size();
        end
    end

endmodule

/* tb/sv/tb_float_key_radix_sorter_unit.sv */
// testbench top of the float key sorter: clock, reset, key stimulus, result stalls and verdict
`timescale 1ns / 1ps

module tb_float_key_radix_sorter_unit;

    localparam int DEPTH         = fkrs_pkg::DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int PHASE_ITEMS   = 8;

    logic                   clk;
    logic                   rst_n;
    logic                   key_valid;
    logic                   key_stall;
    fkrs_pkg::key_beat_t    key_beat;
    logic                   result_valid;
    logic                   result_stall;
    fkrs_pkg::result_beat_t result_beat;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int phase_items;
    int set_size;

    float_key_radix_sorter_unit #(.DEPTH(DEPTH)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_beat     (key_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

    fkrs_sort_checker #(.DEPTH(DEPTH)) sort_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_beat     (key_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // receiver stalls at random, rate set per phase
    always @(negedge clk)
        result_stall = ($urandom_range(99) < recv_stall_pct);

    // zeros, infinities, nans, denormals, extremes of magnitude
    function automatic logic [31:0] special_key(input int idx);
        case (idx)
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7f80_0000;
            3:       return 32'hff80_0000;
            4:       return 32'h7fc0_0000;
            5:       return 32'hffc0_0000;
            6:       return 32'h7f80_0001;
            7:       return 32'hff80_0001;
            8:       return 32'h0000_0001;
            9:       return 32'h8000_0001;
            10:      return 32'h7f7f_ffff;
            11:      return 32'hff7f_ffff;
            12:      return 32'h7fff_ffff;
            13:      return 32'hffff_ffff;
            14:      return 32'h3f80_0000;
            default: return 32'hbf80_0000;
        endcase
    endfunction

    // random key, often close to or equal to the one before
    function automatic logic [31:0] pick_key(input logic [31:0] prior);
        logic [31:0] k;
        case ($urandom_range(9))
            0, 1:    k = special_key($urandom_range(15));
            2:       k = prior;
            3:       k = prior ^ (32'd1 << $urandom_range(31));
            4:       k = {prior[31:23], 23'($urandom)};
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // one key beat, starting and ending at a falling edge
    task automatic send_key(input logic [31:0] bits, input logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            key_valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        key_beat.key_bits = bits;
        key_beat.is_last  = last;
        key_valid         = 1'b1;
        do
            @(posedge clk);
        while (key_stall);
        @(negedge clk);
    endtask

    task automatic send_set(input int size);
        logic [31:0] k;
        k = $urandom;
        for (int i = 0; i < size; i++)
        begin
            k = pick_key(k);
            send_key(k, i == size - 1);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        key_valid      = 1'b0;
        key_beat       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // all special patterns in one scrambled set
        for (int i = 0; i < 16; i++)
            send_key(special_key((i * 7) % 16), i == 15);
        // single key set, duplicate keys, negative zero against positive zero
        send_key(32'h8000_0000, 1'b1);
        send_key(32'h3f80_0000, 1'b0);
        send_key(32'h3f80_0000, 1'b1);
        send_key(32'h0000_0000, 1'b0);
        send_key(32'h8000_0000, 1'b1);

        // random sets under three idling patterns
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct  = (ph == 0) ? 15 : (ph == 1) ? 58 : 0;
            recv_stall_pct = (ph == 0) ? 58 : (ph == 1) ? 15 : 0;
            // overfull set and exactly full set
            if (ph == 0)
                send_set(DEPTH + 3);
            if (ph == 2)
                send_set(DEPTH);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                set_size = $urandom_range(10, 1);
                send_set(set_size);
                phase_items += set_size;
            end
            // hold off until every owed result has been taken
            key_valid = 1'b0;
            wait (pending == 0);
            @(negedge clk);
        end

        key_valid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("float_key_radix_sorter_unit test passed");
        else
            $display("float_key_radix_sorter_unit test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("float_key_radix_sorter_unit test failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/fkrs_pkg.sv
hw/rtl/fkrs_cell.sv
hw/rtl/float_key_radix_sorter_unit.sv
hw/rtl/fkrs_checker.sv
tb/sv/fkrs_sort_checker.sv
tb/sv/tb_float_key_radix_sorter_unit.sv
